/* design/ikt_pkg.sv */
// shared types and codes for the idempotency key table
package ikt_pkg;

	// operation codes
	localparam logic [2:0] OP_BEGIN    = 3'd0;
	localparam logic [2:0] OP_COMPLETE = 3'd1;
	localparam logic [2:0] OP_FAIL     = 3'd2;
	localparam logic [2:0] OP_CONFLICT = 3'd3;
	localparam logic [2:0] OP_RESTORE  = 3'd4;
	localparam logic [2:0] OP_QUERY    = 3'd5;

	// verdict codes
	localparam logic [2:0] V_NEW      = 3'd0;
	localparam logic [2:0] V_INPROG   = 3'd1;
	localparam logic [2:0] V_DONE     = 3'd2;
	localparam logic [2:0] V_CONFLICT = 3'd3;
	localparam logic [2:0] V_FULL     = 3'd4;
	localparam logic [2:0] V_NONE     = 3'd5;

	// entry status codes
	localparam logic [1:0] S_INPROG   = 2'd0;
	localparam logic [1:0] S_DONE     = 2'd1;
	localparam logic [1:0] S_FAILED   = 2'd2;
	localparam logic [1:0] S_CONFLICT = 2'd3;

	// request transfer
	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] op_ident;
		logic [31:0] request_key;
		logic [63:0] payload_digest;
		logic [1:0]  restore_state;
	} ikt_req_t;

	// result transfer
	typedef struct packed {
		logic [2:0]  verdict;
		logic        found;
		logic [1:0]  entry_state;
		logic [63:0] stored_digest;
		logic        has_prior_result;
	} ikt_rsp_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic        go;
		logic        hit_seen;
		logic        free_seen;
		logic [1:0]  status;
		logic [63:0] digest;
	} ikt_token_t;

	// write-back command broadcast to all cells
	typedef struct packed {
		logic        we;
		logic        create;
		logic [1:0]  status;
		logic [63:0] digest;
	} ikt_wr_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_SCAN,
		ST_WRITE
	} ikt_state_t;

endpackage

/* design/ikt_cell.sv */
// one table slot: compares the passing search token and takes write-backs
module ikt_cell #(
	parameter int ID_BITS  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ID_BITS-1:0]  op_ident,
	input  logic [KEY_BITS-1:0] request_key,
	input  ikt_pkg::ikt_token_t tok_in,
	input  ikt_pkg::ikt_wr_t    wr,
	output ikt_pkg::ikt_token_t tok_out
);

	logic                valid_q;
	logic                sel_hit_q;
	logic                sel_free_q;
	logic [ID_BITS-1:0]  id_q;
	logic [KEY_BITS-1:0] key_q;
	logic [63:0]         digest_q;
	logic [1:0]          status_q;
	ikt_pkg::ikt_token_t tok_q;
	ikt_pkg::ikt_token_t tok_d;
	logic                match;
	logic                wr_here;

	// key compare against the broadcast request
	assign match   = valid_q && (id_q == op_ident) && (key_q == request_key);
	assign wr_here = wr.we && (wr.create ? sel_free_q : sel_hit_q);

	// token update: first match and first free slot claim the token
	always_comb begin
		tok_d = tok_in;
		if (tok_in.go) begin
			if (match && !tok_in.hit_seen) begin
				tok_d.hit_seen = 1'b1;
				tok_d.status   = status_q;
				tok_d.digest   = digest_q;
			end
			if (!valid_q && !tok_in.free_seen) begin
				tok_d.free_seen = 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			sel_hit_q  <= 1'b0;
			sel_free_q <= 1'b0;
			tok_q      <= '0;
		end else begin
			tok_q <= tok_d;
			if (tok_in.go) begin
				sel_hit_q  <= match && !tok_in.hit_seen;
				sel_free_q <= !valid_q && !tok_in.free_seen;
			end
			if (wr_here) begin
				valid_q <= 1'b1;
			end
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (wr_here) begin
			id_q     <= op_ident;
			key_q    <= request_key;
			digest_q <= wr.digest;
			status_q <= wr.status;
		end
	end

	assign tok_out = tok_q;

endmodule

/* design/idempotency_key_table_top.sv */
// idempotency key table: sequencer, decision logic and the row of slot cells
//
// channel   direction  handshake                   payload
// request   in         start high, busy low        request (ikt_req_t)
// result    out        done high for one cycle     result  (ikt_rsp_t)
//
// an item goes from accept through a launch state in which the first cell compares,
// a scan state in which each further cell compares in turn and the decision is taken
// as the token leaves the row, and a write-back state that shows the result, then
// back to idle, where the next request can be accepted. reset empties every slot at
// once (valid flags only).
// busy stays high while an item is in flight; the result cannot be stalled.
module idempotency_key_table_top #(
	parameter int TABLE_ENTRIES = 64,
	parameter int OP_IDENT_BITS = 16,
	parameter int KEY_BITS      = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ikt_pkg::ikt_req_t request,
	output logic              busy,
	output logic              done,
	output ikt_pkg::ikt_rsp_t result
);

	ikt_pkg::ikt_state_t  state_q;
	ikt_pkg::ikt_state_t  state_d;
	ikt_pkg::ikt_req_t    req_q;
	ikt_pkg::ikt_rsp_t    result_q;
	ikt_pkg::ikt_wr_t     wr_q;
	logic                 done_q;
	ikt_pkg::ikt_token_t  tok [TABLE_ENTRIES+1];
	ikt_pkg::ikt_token_t  tail;
	logic [OP_IDENT_BITS-1:0] id_bcast;
	logic [KEY_BITS-1:0]      key_bcast;
	logic                 accept;
	logic                 launch;
	logic                 decide;
	logic                 hit;
	logic                 creates;
	logic                 exists;
	logic [1:0]           st_c;
	logic [63:0]          dig_c;
	logic [2:0]           verdict_c;
	ikt_pkg::ikt_rsp_t    rsp_c;
	ikt_pkg::ikt_wr_t     wr_c;

	assign accept = start && !busy;
	assign tail   = tok[TABLE_ENTRIES];

	// key halves widened or cut to the stored widths
	assign id_bcast  = OP_IDENT_BITS'(64'(req_q.op_ident));
	assign key_bcast = KEY_BITS'(64'(req_q.request_key));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ikt_pkg::ST_IDLE:   if (start) state_d = ikt_pkg::ST_LAUNCH;
			ikt_pkg::ST_LAUNCH: state_d = ikt_pkg::ST_SCAN;
			ikt_pkg::ST_SCAN:   if (tail.go) state_d = ikt_pkg::ST_WRITE;
			ikt_pkg::ST_WRITE:  state_d = ikt_pkg::ST_IDLE;
			default:            state_d = ikt_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy   = 1'b1;
		launch = 1'b0;
		decide = 1'b0;
		unique case (state_q)
			ikt_pkg::ST_IDLE:   busy = 1'b0;
			ikt_pkg::ST_LAUNCH: launch = 1'b1;
			ikt_pkg::ST_SCAN:   decide = tail.go;
			ikt_pkg::ST_WRITE:  busy = 1'b1;
			default:            busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ikt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	// token injected at the head of the row
	assign tok[0] = '{go: launch, default: '0};

	// row of slot cells
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		ikt_cell #(
			.ID_BITS  (OP_IDENT_BITS),
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op_ident    (id_bcast),
			.request_key (key_bcast),
			.tok_in      (tok[i]),
			.wr          (wr_q),
			.tok_out     (tok[i+1])
		);
	end

	// decision from the token leaving the row
	always_comb begin
		hit       = tail.hit_seen;
		creates   = !hit && (req_q.operation inside {ikt_pkg::OP_BEGIN, ikt_pkg::OP_COMPLETE,
			ikt_pkg::OP_CONFLICT, ikt_pkg::OP_RESTORE});
		exists    = hit || creates;
		st_c      = hit ? tail.status : ikt_pkg::S_INPROG;
		dig_c     = hit ? tail.digest : 64'd0;
		verdict_c = ikt_pkg::V_NONE;
		case (req_q.operation)
			ikt_pkg::OP_BEGIN: begin
				if (creates) begin
					dig_c     = req_q.payload_digest;
					verdict_c = ikt_pkg::V_NEW;
				end else if (dig_c != req_q.payload_digest || st_c == ikt_pkg::S_CONFLICT) begin
					verdict_c = ikt_pkg::V_CONFLICT;
				end else if (st_c == ikt_pkg::S_DONE) begin
					verdict_c = ikt_pkg::V_DONE;
				end else if (st_c == ikt_pkg::S_FAILED) begin
					verdict_c = ikt_pkg::V_NEW;
				end else begin
					verdict_c = ikt_pkg::V_INPROG;
				end
			end
			ikt_pkg::OP_COMPLETE: st_c = ikt_pkg::S_DONE;
			ikt_pkg::OP_FAIL:     if (hit) st_c = ikt_pkg::S_FAILED;
			ikt_pkg::OP_CONFLICT: st_c = ikt_pkg::S_CONFLICT;
			ikt_pkg::OP_RESTORE: begin
				dig_c = req_q.payload_digest;
				st_c  = req_q.restore_state;
			end
			default: ;
		endcase

		rsp_c.found            = hit;
		rsp_c.verdict          = verdict_c;
		rsp_c.entry_state      = exists ? st_c : 2'd0;
		rsp_c.stored_digest    = exists ? dig_c : 64'd0;
		rsp_c.has_prior_result = exists && (st_c == ikt_pkg::S_DONE);
		wr_c.we                = exists && (req_q.operation inside {ikt_pkg::OP_BEGIN,
			ikt_pkg::OP_COMPLETE, ikt_pkg::OP_FAIL, ikt_pkg::OP_CONFLICT, ikt_pkg::OP_RESTORE});
		wr_c.create            = creates;
		wr_c.status            = st_c;
		wr_c.digest            = dig_c;

		// no free slot for a new entry
		if (creates && !tail.free_seen) begin
			rsp_c.verdict          = ikt_pkg::V_FULL;
			rsp_c.entry_state      = 2'd0;
			rsp_c.stored_digest    = 64'd0;
			rsp_c.has_prior_result = 1'b0;
			wr_c.we                = 1'b0;
		end
	end

	// result and write-back registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			wr_q   <= '0;
		end else begin
			done_q <= decide;
			wr_q   <= decide ? wr_c : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			result_q <= rsp_c;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	// result strobe only in the write-back cycle
	a_done_in_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ikt_pkg::ST_WRITE)
		else $error("result strobe outside write-back");

	// cells are written only in the write-back cycle
	a_wr_in_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q.we |-> state_q == ikt_pkg::ST_WRITE)
		else $error("slot write outside write-back");

	// the token leaves the row only while scanning
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.go |-> state_q == ikt_pkg::ST_SCAN)
		else $error("search token out of step with sequencer");

	// an accepted request launches a search next cycle
	a_accept_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> launch)
		else $error("accepted request not launched");
`endif

endmodule

/* tb/ikt_result_checker.sv */
// result checker for the idempotency key table: predicts each answer and compares it on arrival
module ikt_result_checker
	import ikt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  ikt_req_t request,
	input  logic     done,
	input  ikt_rsp_t result,
	output int       mismatches,
	output int       outstanding,
	output int       results_checked,
	output int       full_answers
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_LIMIT = 40;

	// shadow copy of the slot array
	logic        slot_used   [TABLE_ENTRIES];
	logic [15:0] slot_ident  [TABLE_ENTRIES];
	logic [31:0] slot_key    [TABLE_ENTRIES];
	logic [63:0] slot_digest [TABLE_ENTRIES];
	logic [1:0]  slot_status [TABLE_ENTRIES];

	// answers predicted for accepted requests, oldest first
	ikt_rsp_t predicted_answers[$];

	// print one line per mismatch (up to a limit) and count every one
	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// look the key pair up, apply the operation to the shadow table, return the answer
	function automatic ikt_rsp_t lookup_and_update(input ikt_req_t req);
		int       hit;
		int       free_idx;
		logic     creates;
		ikt_rsp_t rsp;
		hit      = -1;
		free_idx = -1;
		rsp      = '0;
		// first matching slot and lowest free slot
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (slot_used[i]) begin
				if (hit < 0 && slot_ident[i] == req.op_ident && slot_key[i] == req.request_key)
					hit = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		rsp.found = (hit >= 0);
		creates = (hit < 0) && (req.operation == OP_BEGIN || req.operation == OP_COMPLETE ||
			req.operation == OP_CONFLICT || req.operation == OP_RESTORE);

		// no room for a new entry: nothing changes
		if (creates && free_idx < 0) begin
			rsp.verdict = V_FULL;
		end else begin
			rsp.verdict = V_NONE;
			if (creates) begin
				hit                   = free_idx;
				slot_used[hit]        = 1'b1;
				slot_ident[hit]       = req.op_ident;
				slot_key[hit]         = req.request_key;
				slot_digest[hit]      = '0;
				slot_status[hit]      = S_INPROG;
			end
			case (req.operation)
				OP_BEGIN: begin
					if (creates) begin
						slot_digest[hit] = req.payload_digest;
						rsp.verdict      = V_NEW;
					end else if (slot_digest[hit] != req.payload_digest ||
						slot_status[hit] == S_CONFLICT) begin
						rsp.verdict = V_CONFLICT;
					end else if (slot_status[hit] == S_DONE) begin
						rsp.verdict = V_DONE;
					end else if (slot_status[hit] == S_FAILED) begin
						rsp.verdict = V_NEW;
					end else begin
						rsp.verdict = V_INPROG;
					end
				end
				OP_COMPLETE: slot_status[hit] = S_DONE;
				OP_FAIL: begin
					if (hit >= 0)
						slot_status[hit] = S_FAILED;
				end
				OP_CONFLICT: slot_status[hit] = S_CONFLICT;
				OP_RESTORE: begin
					slot_digest[hit] = req.payload_digest;
					slot_status[hit] = req.restore_state;
				end
				default: ;
			endcase
			// entry as it stands after the request
			if (hit >= 0) begin
				rsp.entry_state      = slot_status[hit];
				rsp.stored_digest    = slot_digest[hit];
				rsp.has_prior_result = (slot_status[hit] == S_DONE);
			end
		end
		return rsp;
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		ikt_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				slot_used[i] = 1'b0;
			predicted_answers.delete();
			mismatches      = 0;
			results_checked = 0;
			full_answers    = 0;
			outstanding    <= 0;
		end else begin
			// result transfer: compare with the oldest prediction
			if (done) begin
				if (predicted_answers.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending, verdict %0d",
						result.verdict));
				end else begin
					want = predicted_answers.pop_front();
					results_checked++;
					if (want.verdict == V_FULL)
						full_answers++;
					if (result.verdict !== want.verdict)
						report_mismatch($sformatf("verdict got %0d want %0d",
							result.verdict, want.verdict));
					if (result.found !== want.found)
						report_mismatch($sformatf("found got %0b want %0b",
							result.found, want.found));
					if (result.entry_state !== want.entry_state)
						report_mismatch($sformatf("entry_state got %0d want %0d",
							result.entry_state, want.entry_state));
					if (result.stored_digest !== want.stored_digest)
						report_mismatch($sformatf("stored_digest got %h want %h",
							result.stored_digest, want.stored_digest));
					if (result.has_prior_result !== want.has_prior_result)
						report_mismatch($sformatf("has_prior_result got %0b want %0b",
							result.has_prior_result, want.has_prior_result));
				end
			end
			// request transfer: predict and queue at the tail
			if (start && !busy)
				predicted_answers.insert(predicted_answers.size(), lookup_and_update(request));
			outstanding <= predicted_answers.size();
		end
	end

endmodule

/* tb/idempotency_key_table_top_tb.sv */
// testbench top for the idempotency key table: clock, reset, request stimulus and verdict
module idempotency_key_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ikt_pkg::*;

	localparam int          TABLE_ENTRIES  = 64;
	localparam int          ITEM_TOTAL     = 600;
	localparam int          POOL_IDENTS    = 7;
	localparam int          POOL_KEYS      = 8;
	localparam int          POOL_SIZE      = POOL_IDENTS * POOL_KEYS;
	localparam int          MAX_GAP        = 90;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          TAIL_CYCLES    = TABLE_ENTRIES + 8;
	localparam logic [63:0] ONES64         = 64'hFFFF_FFFF_FFFF_FFFF;

	// operation codes outside the defined set; the block treats them as query
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic     clk;
	logic     arst_n;
	logic     start;
	ikt_req_t request;
	logic     busy;
	logic     done;
	ikt_rsp_t result;

	int errors;
	int pending;
	int checked;
	int full_seen;
	int sent;
	int idle_cycles;

	// key pairs reused so that most requests hit existing entries
	logic [15:0] grid_ident  [POOL_IDENTS];
	logic [31:0] grid_key    [POOL_KEYS];
	logic [63:0] pool_digest [POOL_SIZE];

	idempotency_key_table_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	ikt_result_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.request         (request),
		.done            (done),
		.result          (result),
		.mismatches      (errors),
		.outstanding     (pending),
		.results_checked (checked),
		.full_answers    (full_seen)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles with no transfer", idle_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// present one request and hold it until the block takes it
	task automatic send_op(input logic [2:0] op, input logic [15:0] ident,
		input logic [31:0] key, input logic [63:0] digest, input logic [1:0] restore_to);
		ikt_req_t req;
		req.operation      = op;
		req.op_ident       = ident;
		req.request_key    = key;
		req.payload_digest = digest;
		req.restore_state  = restore_to;
		request <= req;
		start   <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	// stimulus
	initial begin
		int          idx;
		int          burst;
		int          choice;
		logic [2:0]  op;
		logic [15:0] ident;
		logic [31:0] key;
		logic [63:0] digest;
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		sent        = 0;
		idle_cycles = 0;

		// key grid with the extreme values in it
		grid_ident[0] = 16'h0000;
		grid_ident[1] = 16'hFFFF;
		for (int i = 2; i < POOL_IDENTS; i++)
			grid_ident[i] = 16'($urandom);
		grid_key[0] = 32'h0000_0000;
		grid_key[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_KEYS; i++)
			grid_key[i] = $urandom;
		for (int i = 0; i < POOL_SIZE; i++)
			pool_digest[i] = (i % 9 == 0) ? 64'h0 : {$urandom, $urandom};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every verdict path but table full on a near-empty table, back to back
		send_op(OP_QUERY,     16'h0000, 32'h0000_0000, ONES64, S_DONE);
		send_op(OP_FAIL,      16'hFFFF, 32'hFFFF_FFFF, ONES64, S_CONFLICT);
		send_op(OP_BEGIN,     16'h0000, 32'h0000_0000, ONES64, S_INPROG);
		send_op(OP_BEGIN,     16'h0000, 32'h0000_0000, ONES64, S_INPROG);
		send_op(OP_BEGIN,     16'h0000, 32'h0000_0000, 64'h0,  S_INPROG);
		send_op(OP_COMPLETE,  16'h0000, 32'h0000_0000, 64'h0,  S_INPROG);
		send_op(OP_BEGIN,     16'h0000, 32'h0000_0000, ONES64, S_INPROG);
		send_op(OP_FAIL,      16'h0000, 32'h0000_0000, 64'h0,  S_INPROG);
		send_op(OP_BEGIN,     16'h0000, 32'h0000_0000, ONES64, S_INPROG);
		send_op(OP_CONFLICT,  16'h0000, 32'h0000_0000, 64'h0,  S_INPROG);
		send_op(OP_BEGIN,     16'h0000, 32'h0000_0000, ONES64, S_INPROG);
		send_op(OP_COMPLETE,  16'hFFFF, 32'hFFFF_FFFF, ONES64, S_INPROG);
		send_op(OP_BEGIN,     16'hFFFF, 32'hFFFF_FFFF, 64'h0,  S_INPROG);
		send_op(OP_CONFLICT,  16'h8001, 32'h8000_0001, ONES64, S_DONE);
		send_op(OP_RESTORE,   16'h0000, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001, S_FAILED);
		send_op(OP_RESTORE,   16'h0000, 32'h0000_0000, 64'h0123_4567_89AB_CDEF, S_INPROG);
		send_op(OP_BEGIN,     16'h0000, 32'h0000_0000, 64'h0123_4567_89AB_CDEF, S_INPROG);
		send_op(OP_UNUSED_LO, 16'h0000, 32'h0000_0000, ONES64, S_CONFLICT);
		send_op(OP_UNUSED_HI, 16'h5555, 32'hAAAA_AAAA, 64'h0,  S_INPROG);
		send_op(OP_RESTORE,   16'h0000, 32'h0000_0000, ONES64, S_CONFLICT);
		send_op(OP_QUERY,     16'hFFFF, 32'h0000_0000, 64'h0,  S_INPROG);
		send_op(OP_FAIL,      16'hFFFF, 32'hFFFF_FFFF, 64'h0,  S_INPROG);
		send_op(OP_BEGIN,     16'hFFFF, 32'hFFFF_FFFF, 64'h0,  S_INPROG);

		// random: mostly pooled keys with their usual digest, some fresh keys that fill the table
		while (sent < ITEM_TOTAL) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				if ($urandom_range(0, 9) == 0) begin
					ident  = 16'($urandom);
					key    = $urandom;
					digest = {$urandom, $urandom};
				end else begin
					idx    = $urandom_range(0, POOL_SIZE - 1);
					ident  = grid_ident[idx % POOL_IDENTS];
					key    = grid_key[idx / POOL_IDENTS];
					digest = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : pool_digest[idx];
				end
				choice = $urandom_range(0, 99);
				if (choice < 30)
					op = OP_BEGIN;
				else if (choice < 45)
					op = OP_COMPLETE;
				else if (choice < 57)
					op = OP_FAIL;
				else if (choice < 65)
					op = OP_CONFLICT;
				else if (choice < 77)
					op = OP_RESTORE;
				else if (choice < 96)
					op = OP_QUERY;
				else
					op = (choice < 98) ? OP_UNUSED_LO : OP_UNUSED_HI;
				send_op(op, ident, key, digest, 2'($urandom_range(0, 3)));
			end
			// gap after most bursts, none after some
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
			end
		end
		start <= 1'b0;

		// drain, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d answers checked against the prediction", sent, checked);
		$display("%0d answers were table full, %0d mismatches", full_seen, errors);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
